// File: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Commands from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;   // start of a request: drop all trackers
        logic scan;    // a key/rank pair is present for the search pass
        logic update;  // a rank is present for the rewrite pass
        logic touch;   // rewrite pass ages only entries younger than the hit
    } unit_ctl_t;

    // What the search pass has found so far.
    typedef struct packed {
        logic found;
        logic victim_found;
        logic free_found;
    } unit_stat_t;

endpackage

// File: hw/rtl/lkvc_ram.sv
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/lkvc_unit.sv
module lkvc_unit import lkvc_pkg::*; #(
    parameter int IW = 4,
    parameter int RW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  unit_ctl_t         ctl,
    input  logic [IW-1:0]     idx,
    input  logic              ent_valid,
    input  logic [DATA_W-1:0] key_rd,
    input  logic [DATA_W-1:0] lookup_key,
    input  logic [RW-1:0]     rank_rd,
    input  logic [IW-1:0]     target,
    output unit_stat_t        stat,
    output logic [IW-1:0]     found_idx,
    output logic [IW-1:0]     victim_idx,
    output logic [IW-1:0]     free_idx,
    output logic [RW-1:0]     rank_wdata
);

    logic          found_reg;
    logic          victim_reg;
    logic          free_reg;
    logic [IW-1:0] found_idx_reg;
    logic [RW-1:0] found_rank_reg;
    logic [IW-1:0] victim_idx_reg;
    logic [RW-1:0] best_reg;
    logic [IW-1:0] free_idx_reg;

    logic [RW-1:0] cmp_a;
    logic [RW-1:0] cmp_b;
    logic          cmp_lt;
    logic          key_match;
    logic          take_found;
    logic          take_victim;
    logic          take_free;

    // The one rank comparator: during the search it asks whether this rank is
    // older than the best so far, during the rewrite whether it is younger than
    // the rank of the hit entry.
    assign cmp_a  = ctl.update ? rank_rd : best_reg;
    assign cmp_b  = ctl.update ? found_rank_reg : rank_rd;
    assign cmp_lt = cmp_a < cmp_b;

    assign key_match   = ent_valid && (key_rd == lookup_key);
    assign take_found  = ctl.scan && key_match && !found_reg;
    assign take_victim = ctl.scan && ent_valid && (!victim_reg || cmp_lt);
    assign take_free   = ctl.scan && !ent_valid && !free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            victim_reg <= 1'b0;
            free_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg  <= 1'b0;
            victim_reg <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            if (take_found)
            begin
                found_reg <= 1'b1;
            end
            if (take_victim)
            begin
                victim_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_found)
        begin
            found_idx_reg  <= idx;
            found_rank_reg <= rank_rd;
        end
        if (take_victim)
        begin
            victim_idx_reg <= idx;
            best_reg       <= rank_rd;
        end
        if (take_free)
        begin
            free_idx_reg <= idx;
        end
    end

    always_comb
    begin
        if (idx == target)
        begin
            rank_wdata = '0;
        end
        else if (ent_valid && (!ctl.touch || cmp_lt))
        begin
            rank_wdata = rank_rd + RW'(1);
        end
        else
        begin
            rank_wdata = rank_rd;
        end
    end

    assign stat.found        = found_reg;
    assign stat.victim_found = victim_reg;
    assign stat.free_found   = free_reg;
    assign found_idx         = found_idx_reg;
    assign victim_idx        = victim_idx_reg;
    assign free_idx          = free_idx_reg;

endmodule

// File: hw/rtl/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
// A transaction on the s_ side carries a get (s_tuser 0) or a put (s_tuser 1)
// and yields exactly one transaction on the m_ side: m_tuser is the hit flag
// and m_tdata the stored value on a get hit, zero otherwise. Keys, values and
// recency ranks sit in three single-port-read RAMs, and one compare unit walks
// them an entry per cycle. A search pass reads every key and rank to find
// the match, the oldest entry and the lowest free slot; on a hit or a put a
// second pass then rewrites every rank through the rank RAM's one write
// port, and a get miss goes straight to its result. The block takes one
// request at a time; a finished result waits in the output register while
// the next request is accepted. Write cfg_wdata (capacity, 0 acts as 1,
// above ENTRIES acts as ENTRIES) only while no request is in flight. There
// is no clearing pass after reset.
module lru_key_value_cache_core import lkvc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,   // capacity_in_use
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*DATA_W-1:0] s_tdata,     // [31:0] lookup_key, [63:32] write_value
    input  logic                s_tuser,     // [0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,     // [31:0] read_value
    output logic                m_tuser      // [0] hit
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int LW = (OW > CAP_W) ? OW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_UPD,
        S_UPD_END,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic                pscan_reg, pscan_next;
    logic                pupd_reg, pupd_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [OW-1:0]       occ_reg, occ_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic                put_reg, put_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       target_reg, target_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    unit_ctl_t           ctl;
    unit_stat_t          stat;
    logic [IW-1:0]       found_idx;
    logic [IW-1:0]       victim_idx;
    logic [IW-1:0]       free_idx;
    logic [RW-1:0]       rank_wdata;
    logic [RW-1:0]       rank_rd;
    logic [DATA_W-1:0]   key_rd;
    logic [DATA_W-1:0]   val_rd;

    logic                accept;
    logic                last_cnt;
    logic [LW-1:0]       cap_ext;
    logic [LW-1:0]       limit;
    logic                evict;
    logic                insert;
    logic [IW-1:0]       target_c;
    logic                key_we;
    logic                val_we;

    assign accept   = s_tvalid && s_tready;
    assign last_cnt = (cnt_reg == IW'(ENTRIES - 1));

    assign cap_ext = LW'(cap_reg);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            limit = LW'(1);
        end
        else if (cap_ext > LW'(ENTRIES))
        begin
            limit = LW'(ENTRIES);
        end
        else
        begin
            limit = cap_ext;
        end
    end

    assign insert = put_reg && !stat.found;
    assign evict  = insert && (LW'(occ_reg) >= limit);

    // After an eviction the lowest free slot is the lower of the victim and
    // the first slot that was already free.
    always_comb
    begin
        if (stat.found)
        begin
            target_c = found_idx;
        end
        else if (evict && (!stat.free_found || (victim_idx < free_idx)))
        begin
            target_c = victim_idx;
        end
        else
        begin
            target_c = free_idx;
        end
    end

    assign key_we = (state_reg == S_DECIDE) && insert;
    assign val_we = (state_reg == S_DECIDE) && put_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pscan_next    = (state_reg == S_SCAN);
        pupd_next     = (state_reg == S_UPD);
        pidx_next     = cnt_reg;
        valid_next    = valid_reg;
        occ_next      = occ_reg;
        cap_next      = cfg_we ? cfg_wdata : cap_reg;
        put_next      = put_reg;
        hit_next      = hit_reg;
        target_next   = target_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    put_next   = (s_tuser == REQ_PUT);
                    key_next   = s_tdata[DATA_W-1:0];
                    val_next   = s_tdata[2*DATA_W-1:DATA_W];
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_cnt)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                hit_next    = stat.found;
                target_next = target_c;
                cnt_next    = '0;
                if (evict)
                begin
                    valid_next[victim_idx] = 1'b0;
                end
                if (insert)
                begin
                    valid_next[target_c] = 1'b1;
                end
                occ_next = occ_reg + OW'(insert) - OW'(evict);
                if (stat.found || insert)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UPD:
            begin
                if (last_cnt)
                begin
                    state_next = S_UPD_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_UPD_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_reg;
                    m_tdata_next  = (hit_reg && !put_reg) ? val_rd : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pscan_reg    <= 1'b0;
            pupd_reg     <= 1'b0;
            valid_reg    <= '0;
            occ_reg      <= '0;
            cap_reg      <= CAP_RESET;
            put_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pscan_reg    <= pscan_next;
            pupd_reg     <= pupd_next;
            valid_reg    <= valid_next;
            occ_reg      <= occ_next;
            cap_reg      <= cap_next;
            put_reg      <= put_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        target_reg  <= target_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign ctl.clear  = accept;
    assign ctl.scan   = pscan_reg;
    assign ctl.update = pupd_reg;
    assign ctl.touch  = hit_reg;

    lkvc_unit #(
        .IW (IW),
        .RW (RW)
    ) u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .idx        (pidx_reg),
        .ent_valid  (valid_reg[pidx_reg]),
        .key_rd     (key_rd),
        .lookup_key (key_reg),
        .rank_rd    (rank_rd),
        .target     (target_reg),
        .stat       (stat),
        .found_idx  (found_idx),
        .victim_idx (victim_idx),
        .free_idx   (free_idx),
        .rank_wdata (rank_wdata)
    );

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (target_c),
        .wdata (key_reg),
        .raddr (cnt_reg),
        .rdata (key_rd)
    );

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (target_c),
        .wdata (val_reg),
        .raddr (found_idx),
        .rdata (val_rd)
    );

    lkvc_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (pupd_reg),
        .waddr (pidx_reg),
        .wdata (rank_wdata),
        .raddr (cnt_reg),
        .rdata (rank_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The occupancy count always agrees with the valid bits.
    a_occ_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg)
    ) else $error("occupancy count disagrees with valid bits");

    // Occupancy never passes the number of slots.
    a_occ_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= ENTRIES
    ) else $error("occupancy above slot count");

    // A request is followed by a busy period, never by a second acceptance.
    a_one_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready
    ) else $error("second request taken while busy");

    // A miss result never carries a value.
    a_miss_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0)
    ) else $error("miss result with nonzero value");

endmodule

// File: sim/lru_key_value_cache_core_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;
    import lkvc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 192;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } cache_reply_t;

    // Mirror of the cache contents and recency order; one reply is queued per request.
    class lru_scoreboard;
        logic [DATA_W-1:0] keys [ENTRIES];
        logic [DATA_W-1:0] vals [ENTRIES];
        bit                valid [ENTRIES];
        int unsigned       rank [ENTRIES];
        int unsigned       fill;
        logic [CAP_W-1:0]  capacity;
        cache_reply_t      pending [$];
        int                errors;
        int                requests;
        int                hits;
        int                puts;
        int                evictions;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid[i] = 1'b0;
                rank[i]  = 0;
            end
            fill      = 0;
            capacity  = CAP_RESET;
            errors    = 0;
            requests  = 0;
            hits      = 0;
            puts      = 0;
            evictions = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function void note_request(logic put, logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
            cache_reply_t r;
            int           slot;
            int           victim;
            int           lim;
            int unsigned  age;
            requests++;
            if (put == REQ_PUT)
                puts++;
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && valid[i] && keys[i] == key)
                    slot = i;
            r.hit   = (slot >= 0);
            r.value = '0;
            if (slot >= 0)
            begin
                hits++;
                age = rank[slot];
                for (int i = 0; i < ENTRIES; i++)
                    if (valid[i] && rank[i] < age)
                        rank[i]++;
                rank[slot] = 0;
                if (put == REQ_PUT)
                    vals[slot] = val;
                else
                    r.value = vals[slot];
            end
            else if (put == REQ_PUT)
            begin
                lim = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
                // A lowered capacity still evicts only one entry per inserting put.
                if (fill >= lim)
                begin
                    victim = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (valid[i] && (victim < 0 || rank[i] > rank[victim]))
                            victim = i;
                    valid[victim] = 1'b0;
                    rank[victim]  = 0;
                    fill--;
                    evictions++;
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !valid[i])
                        slot = i;
                for (int i = 0; i < ENTRIES; i++)
                    if (valid[i])
                        rank[i]++;
                valid[slot] = 1'b1;
                keys[slot]  = key;
                vals[slot]  = val;
                rank[slot]  = 0;
                fill++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic hit, logic [DATA_W-1:0] value);
            cache_reply_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: hit %0b value %h",
                         $time, hit, value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (hit !== want.hit)
            begin
                $display("%0t: hit flag mismatch: expected %0b, actual %0b",
                         $time, want.hit, hit);
                errors++;
            end
            if (value !== want.value)
            begin
                $display("%0t: read value mismatch: expected %h, actual %h",
                         $time, want.value, value);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tuser;

    lru_scoreboard       sb;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    bit                  long_hold_req  = 1'b0;
    bit                  long_hold_done = 1'b0;
    logic [DATA_W-1:0]   key_pool [32];

    lru_key_value_cache_core #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both sides are sampled here, at the edge where each transaction completes.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W]);
        end
    end

    initial
    begin : receiver
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(input logic put, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= put;
        s_tdata  <= {val, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Wait for a clock edge first, so that the monitor has logged the last accepted request.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_capacity(cap);
    endtask

    initial
    begin : main
        logic [CAP_W-1:0] cap;
        int               eff;
        int               pool_n;
        int               mode;
        logic [DATA_W-1:0] key;
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_GET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys and values, update on hit, eviction at a small capacity.
        write_capacity(5'd3);
        send_request(REQ_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(REQ_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PUT, 32'h1234_5678, 32'h0000_0000);
        send_request(REQ_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_GET, 32'h1234_5678, 32'h0000_0000);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'hA5A5_A5A5, 32'h0000_0000);
        send_request(REQ_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_request(REQ_GET, 32'h5A5A_5A5A, 32'h0000_0000);
        wait_results_done();
        // A capacity of zero behaves as a single entry.
        write_capacity(5'd0);
        send_request(REQ_PUT, 32'h0000_0001, 32'h0000_0011);
        send_request(REQ_PUT, 32'h0000_0002, 32'h0000_0022);
        send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);
        send_request(REQ_PUT, 32'h0000_0002, 32'hDEAD_BEEF);
        send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_results_done();
            case (p)
                0: cap = 5'd16;
                1: cap = 5'd5;
                2: cap = 5'd31;
                3: cap = 5'd1;
                4: cap = 5'd12;
                5: cap = 5'd3;   // lowered below the occupancy left by the previous phase
                6: cap = 5'd16;
                default: cap = 5'd8;
            endcase
            write_capacity(cap);
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 70 : ((mode == 3) ? 34 : 0);
            recv_stall_pct = (mode == 2) ? 70 : ((mode == 3) ? 34 : 0);
            if (p == 4)
                long_hold_req = 1'b1;
            eff    = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
            pool_n = eff + eff / 2 + 2;
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < 32; i++)
                key_pool[i] = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly keys from a small pool so hits and evictions are frequent.
                if ($urandom_range(9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(pool_n - 1)];
                send_request($urandom_range(1) ? REQ_PUT : REQ_GET, key, $urandom());
            end
        end

        wait_results_done();
        repeat (2 * ENTRIES + 15) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Checked %0d requests: %0d hits, %0d puts, %0d evictions.",
                 sb.requests, sb.hits, sb.puts, sb.evictions);
        $display("Capacities from 0 to 31 with a cut below occupancy, idle and stall mixes,");
        $display("and a %0d-cycle receiver hold-off.", LONG_HOLD);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
